/* rtl/square_channel_frequency_sweep_assert.svh */
// Assertion macros used by the sweep unit checker.
`ifndef SQUARE_CHANNEL_FREQUENCY_SWEEP_ASSERT_SVH
`define SQUARE_CHANNEL_FREQUENCY_SWEEP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SCFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sweep unit check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define SCFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sweep unit check failed");

`endif

/* rtl/scfs_pkg.sv */
// Types, constants and the sweep step function of the square channel sweep unit.
package scfs_pkg;

	localparam int FREQ_W  = 11;
	localparam int CNT_W   = 4;
	localparam int PER_W   = 3;
	localparam int SHIFT_W = 3;
	localparam int IDX_W   = 2;
	localparam int DATA_W  = 3;

	typedef logic [FREQ_W-1:0]  freq_t;
	typedef logic [CNT_W-1:0]   count_t;
	typedef logic [PER_W-1:0]   period_t;
	typedef logic [SHIFT_W-1:0] shift_t;
	typedef logic [IDX_W-1:0]   cfg_idx_t;
	typedef logic [DATA_W-1:0]  cfg_data_t;

	localparam freq_t FREQ_MAX = {FREQ_W{1'b1}};

	// Register indexes of the configuration port
	localparam cfg_idx_t REG_PERIOD = 2'd0;
	localparam cfg_idx_t REG_SHIFT  = 2'd1;
	localparam cfg_idx_t REG_NEGATE = 2'd2;

	// Input word kinds
	localparam logic MODE_TICK    = 1'b0;
	localparam logic MODE_TRIGGER = 1'b1;

	// A period of zero reloads as eight
	localparam count_t PERIOD_ZERO_RELOAD = 4'd8;

	typedef struct packed {
		freq_t freq;
		logic  overflow;
	} step_t;

	// One sweep step: shadow +/- (shadow >> shift), clamped at the maximum; a zero shift keeps shadow
	function automatic step_t sweep_step(freq_t shadow, shift_t shift, logic negate);
		logic [FREQ_W:0] delta;
		logic [FREQ_W:0] next;
		step_t           res;
		delta = {1'b0, shadow} >> shift;
		if (negate) begin
			next = {1'b0, shadow} - delta;
		end else begin
			next = {1'b0, shadow} + delta;
		end
		res.overflow = 1'b0;
		res.freq     = shadow;
		if (shift != '0) begin
			if (next > {1'b0, FREQ_MAX}) begin
				res.freq     = FREQ_MAX;
				res.overflow = 1'b1;
			end else begin
				res.freq = next[FREQ_W-1:0];
			end
		end
		return res;
	endfunction

	// Counter reload value for a period setting
	function automatic count_t reload_value(period_t period);
		return (period == '0) ? PERIOD_ZERO_RELOAD : {1'b0, period};
	endfunction

endpackage

/* rtl/square_channel_frequency_sweep.sv */
// Square channel frequency sweep unit: trigger and tick words in, one result word out each.
// Each input word is evaluated in the cycle it is accepted, against the shadow frequency,
// period counter and active flag, and its result word is loaded into the output register;
// the unit takes one word per cycle and delivers it in the next cycle. The output register is
// the only throttle: a new word is taken whenever the register is empty or being drained in
// the same cycle. Configuration writes are taken at any time (cfg_ready is always high) and
// are meant to be done while no word is in flight. A trigger loads the shadow frequency and
// runs one step at once; a tick, while active, counts the period down and steps on expiry.
module square_channel_frequency_sweep (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  scfs_pkg::cfg_idx_t cfg_index,
	input  scfs_pkg::cfg_data_t cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  scfs_pkg::freq_t    start_frequency,
	output logic               out_valid,
	input  logic               out_ready,
	output scfs_pkg::freq_t    frequency,
	output logic               frequency_written,
	output logic               sweep_enabled
);
	import scfs_pkg::*;

	period_t period_q;
	shift_t  shift_q;
	logic    negate_q;

	freq_t   shadow_q;
	count_t  count_q;
	logic    active_q;

	logic    out_valid_q;
	freq_t   freq_q;
	logic    written_q;
	logic    enabled_q;

	logic    in_accept;
	freq_t   step_src;
	step_t   step_res;
	logic    expire;
	freq_t   shadow_d;
	count_t  count_d;
	logic    active_d;
	logic    written_d;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;

	// Write configuration registers; ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
			shift_q  <= '0;
			negate_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PERIOD: period_q <= cfg_data[PER_W-1:0];
				REG_SHIFT:  shift_q  <= cfg_data[SHIFT_W-1:0];
				REG_NEGATE: negate_q <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	// Run one sweep step on the trigger frequency or the current shadow
	assign step_src = (mode == MODE_TRIGGER) ? start_frequency : shadow_q;
	assign step_res = sweep_step(step_src, shift_q, negate_q);
	assign expire   = (count_q <= count_t'(1));

	// Next state for this word
	always_comb begin
		shadow_d  = shadow_q;
		count_d   = count_q;
		active_d  = active_q;
		written_d = 1'b0;
		if (mode == MODE_TRIGGER) begin
			shadow_d = step_res.freq;
			count_d  = reload_value(period_q);
			active_d = ((period_q != '0) || (shift_q != '0)) && !step_res.overflow;
		end else if (active_q) begin
			if (expire) begin
				shadow_d  = step_res.freq;
				count_d   = reload_value(period_q);
				active_d  = !step_res.overflow;
				written_d = 1'b1;
			end else begin
				count_d = count_q - count_t'(1);
			end
		end
	end

	// Advance sweep state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_q <= '0;
			count_q  <= '0;
			active_q <= 1'b0;
		end else if (in_accept) begin
			shadow_q <= shadow_d;
			count_q  <= count_d;
			active_q <= active_d;
		end
	end

	// Hold the result word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			freq_q    <= shadow_d;
			written_q <= written_d;
			enabled_q <= active_d;
		end
	end

	assign out_valid         = out_valid_q;
	assign frequency         = freq_q;
	assign frequency_written = written_q;
	assign sweep_enabled     = enabled_q;

endmodule

/* rtl/scfs_checker.sv */
// Port-level checker for the square channel sweep unit, with its bind.
`include "square_channel_frequency_sweep_assert.svh"

module scfs_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input scfs_pkg::freq_t frequency,
	input logic            frequency_written,
	input logic            sweep_enabled
);
	import scfs_pkg::*;

	// Output word holds while stalled
	`SCFS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	// Every accepted word shows up on the next cycle
	`SCFS_ASSERT_NEXT(a_accept_result, clk, arst_n, in_valid && in_ready, out_valid)
	// An empty output register never blocks input
	`SCFS_ASSERT_NOW(a_empty_ready, clk, arst_n, !out_valid, in_ready)
	// A write-back that disabled the unit must have clamped at the maximum
	`SCFS_ASSERT_NOW(a_clamp_disable, clk, arst_n,
		out_valid && frequency_written && !sweep_enabled, frequency == FREQ_MAX)

endmodule

bind square_channel_frequency_sweep scfs_checker u_scfs_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_valid),
	.in_ready          (in_ready),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.frequency         (frequency),
	.frequency_written (frequency_written),
	.sweep_enabled     (sweep_enabled)
);
